// ----- rtl/ctok_pkg.sv -----
// shared types and constants of the c token splitter
`default_nettype none

package ctok_pkg;

    // most bytes one source byte can produce
    localparam int MAX_OUT   = 4;
    localparam int OUT_IDX_W = $clog2(MAX_OUT);
    localparam int OUT_CNT_W = $clog2(MAX_OUT + 1);

    // depth of the queue between lexer and serializer (power of two)
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_NL = 8'd10;

    // bytes produced by one source byte, data[0] goes out first
    typedef struct packed {
        logic [MAX_OUT-1:0][7:0] data;
        logic [OUT_CNT_W-1:0]    cnt;
    } bundle_t;

    // append one byte to a bundle, extra bytes past the limit are dropped
    function automatic bundle_t emit(input bundle_t b, input logic [7:0] c);
        bundle_t r;
        r = b;
        if (b.cnt < OUT_CNT_W'(MAX_OUT)) begin
            r.data[b.cnt[OUT_IDX_W-1:0]] = c;
            r.cnt = b.cnt + OUT_CNT_W'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ctok_front.sv -----
// lexer front end: classifies each source byte and builds its output bundle
`default_nettype none

module ctok_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_fire,
    input  wire logic [7:0]       in_byte,
    input  wire logic             in_last,
    output ctok_pkg::bundle_t     bundle
);

    typedef enum logic [3:0] {
        M_IDLE  = 4'd0,
        M_NUM   = 4'd1,
        M_WORD  = 4'd2,
        M_OP    = 4'd3,
        M_SLASH = 4'd4,
        M_BLOCK = 4'd5,
        M_LINE  = 4'd6,
        M_CHAR  = 4'd7,
        M_STR   = 4'd8
    } mode_t;

    localparam logic [7:0] CH_SQUOTE = 8'd39;
    localparam logic [7:0] CH_DQUOTE = 8'd34;
    localparam logic [7:0] CH_BSLASH = 8'd92;
    localparam logic [7:0] CH_USCORE = 8'd95;
    localparam logic [7:0] CH_SLASH  = 8'd47;
    localparam logic [7:0] CH_STAR   = 8'd42;
    localparam logic [7:0] CH_EQ     = 8'd61;

    mode_t      mode_reg, mode_next;
    logic [7:0] held_reg, held_next;
    logic       prev_reg, prev_next;
    logic       restart;
    ctok_pkg::bundle_t b;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'd65) && (c <= 8'd90)) || ((c >= 8'd97) && (c <= 8'd122));
    endfunction

    function automatic logic is_op_start(input logic [7:0] c);
        return c == "+" || c == "-" || c == "*" || c == "=" || c == "&" ||
               c == "|" || c == "^" || c == "%" || c == "!" || c == ">" ||
               c == "<";
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return c == "~" || c == "#" || c == "[" || c == "]" || c == "{" ||
               c == "}" || c == ";" || c == ":" || c == "(" || c == ")" ||
               c == "?" || c == ".";
    endfunction

    function automatic logic op_pairs(input logic [7:0] first, input logic [7:0] c);
        logic r;
        case (first)
            "+":     r = (c == "+") || (c == "=");
            "-":     r = (c == "-") || (c == ">") || (c == "=");
            "&":     r = (c == "&") || (c == "=");
            "|":     r = (c == "|") || (c == "=");
            ">":     r = (c == ">") || (c == "=");
            "<":     r = (c == "<") || (c == "=");
            "*", "=", "^", "%", "!": r = (c == "=");
            default: r = 1'b0;
        endcase
        return r;
    endfunction

    always_comb begin
        b         = '0;
        mode_next = mode_reg;
        held_next = held_reg;
        prev_next = prev_reg;
        restart   = 1'b0;

        case (mode_reg)
            M_NUM: begin
                if (is_digit(in_byte)) begin
                    b = ctok_pkg::emit(b, in_byte);
                end else begin
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    restart = 1'b1;
                end
            end
            M_WORD: begin
                if (is_letter(in_byte) || in_byte == CH_USCORE) begin
                    b = ctok_pkg::emit(b, in_byte);
                end else begin
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    restart = 1'b1;
                end
            end
            M_OP: begin
                if (op_pairs(held_reg, in_byte)) begin
                    b = ctok_pkg::emit(b, in_byte);
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    mode_next = M_IDLE;
                end else begin
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    restart = 1'b1;
                end
            end
            M_SLASH: begin
                if (in_byte == CH_STAR) begin
                    mode_next = M_BLOCK;
                    prev_next = 1'b1;
                end else if (in_byte == CH_SLASH) begin
                    mode_next = M_LINE;
                end else if (in_byte == CH_EQ) begin
                    b = ctok_pkg::emit(b, CH_SLASH);
                    b = ctok_pkg::emit(b, CH_EQ);
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    mode_next = M_IDLE;
                end else begin
                    b = ctok_pkg::emit(b, CH_SLASH);
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    restart = 1'b1;
                end
            end
            M_BLOCK: begin
                // opening star counts, so slash star slash closes
                if (prev_reg && in_byte == CH_SLASH) begin
                    mode_next = M_IDLE;
                    prev_next = 1'b0;
                end else begin
                    prev_next = (in_byte == CH_STAR);
                end
            end
            M_LINE: begin
                if (in_byte == ctok_pkg::CH_NL) mode_next = M_IDLE;
            end
            M_CHAR: begin
                b = ctok_pkg::emit(b, in_byte);
                if (in_byte == CH_SQUOTE) begin
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    mode_next = M_IDLE;
                end
            end
            M_STR: begin
                b = ctok_pkg::emit(b, in_byte);
                if (in_byte == CH_DQUOTE && !prev_reg) begin
                    b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
                    mode_next = M_IDLE;
                    prev_next = 1'b0;
                end else begin
                    prev_next = (in_byte == CH_BSLASH);
                end
            end
            default: begin
                // idle and unused codes
                if (in_byte == " " || in_byte == 8'd9 || in_byte == ctok_pkg::CH_NL) begin
                    mode_next = M_IDLE;
                end else begin
                    restart = 1'b1;
                end
            end
        endcase

        // terminating byte starts over from idle
        if (restart) begin
            mode_next = M_IDLE;
            if (is_op_start(in_byte)) begin
                b = ctok_pkg::emit(b, in_byte);
                held_next = in_byte;
                mode_next = M_OP;
            end else if (in_byte == CH_SLASH) begin
                mode_next = M_SLASH;
            end else if (is_punct(in_byte)) begin
                b = ctok_pkg::emit(b, in_byte);
                b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
            end else if (in_byte == CH_SQUOTE) begin
                b = ctok_pkg::emit(b, in_byte);
                mode_next = M_CHAR;
            end else if (in_byte == CH_DQUOTE) begin
                b = ctok_pkg::emit(b, in_byte);
                prev_next = 1'b0;
                mode_next = M_STR;
            end else if (is_digit(in_byte)) begin
                b = ctok_pkg::emit(b, in_byte);
                mode_next = M_NUM;
            end else if (is_letter(in_byte)) begin
                b = ctok_pkg::emit(b, in_byte);
                mode_next = M_WORD;
            end
        end

        // end of source: finish pending token, drop open literal or comment
        if (in_last) begin
            if (mode_next == M_NUM || mode_next == M_WORD || mode_next == M_OP) begin
                b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
            end else if (mode_next == M_SLASH) begin
                b = ctok_pkg::emit(b, CH_SLASH);
                b = ctok_pkg::emit(b, ctok_pkg::CH_NL);
            end
            mode_next = M_IDLE;
            held_next = 8'd0;
            prev_next = 1'b0;
        end
    end

    assign bundle = b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_IDLE;
            held_reg <= 8'd0;
            prev_reg <= 1'b0;
        end else if (in_fire) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
            prev_reg <= prev_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctok_queue.sv -----
// short bundle queue between lexer and serializer
`default_nettype none

module ctok_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire ctok_pkg::bundle_t push_data,
    input  wire logic              pop,
    output ctok_pkg::bundle_t      pop_data,
    output logic                   full,
    output logic                   empty
);

    ctok_pkg::bundle_t                entry_reg [ctok_pkg::QDEPTH];
    logic [ctok_pkg::QPTR_W-1:0]      wr_ptr_reg, rd_ptr_reg;
    logic [ctok_pkg::QCNT_W-1:0]      count_reg;

    assign full     = (count_reg == ctok_pkg::QCNT_W'(ctok_pkg::QDEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + ctok_pkg::QPTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + ctok_pkg::QPTR_W'(1);
            if (push && !pop) begin
                count_reg <= count_reg + ctok_pkg::QCNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - ctok_pkg::QCNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/ctok_back.sv -----
// serializer: sends each bundle out one byte per word, tlast on its final byte
`default_nettype none

module ctok_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_empty,
    input  wire ctok_pkg::bundle_t q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,
    output logic                   m_tlast
);

    logic [ctok_pkg::MAX_OUT-1:0][7:0] data_reg;
    logic [ctok_pkg::OUT_CNT_W-1:0]    cnt_reg;
    logic [ctok_pkg::OUT_IDX_W-1:0]    idx_reg;
    logic                              busy_reg;
    logic                              at_last;
    logic                              m_fire;

    assign at_last  = ({1'b0, idx_reg} + ctok_pkg::OUT_CNT_W'(1)) == cnt_reg;
    assign m_fire   = busy_reg && m_tready;
    assign q_pop    = !q_empty && (!busy_reg || (m_fire && at_last));
    assign m_tvalid = busy_reg;
    assign m_tdata  = data_reg[idx_reg];
    assign m_tlast  = at_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (q_pop) begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end else if (m_fire) begin
            if (at_last) begin
                busy_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + ctok_pkg::OUT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            data_reg <= q_data.data;
            cnt_reg  <= q_data.cnt;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/c_token_splitter.sv -----
// top level of the streaming c tokenizer
// Streaming C tokenizer. Source bytes enter on the s_ side, one per word, with
// s_tlast on the final byte of a source; tokens leave on the m_ side one byte
// per word, each token followed by a newline (10), and m_tlast marks the final
// byte produced by one source byte. Blanks are skipped, unknown bytes dropped
// and comments removed. The lexer accepts one byte per cycle whenever the
// four-entry bundle queue has room; a source byte that produces nothing takes
// no queue slot. The output side sends one byte per cycle while m_tready is
// high, so the sustained rate is set by the serializer: a source byte that
// yields n result bytes takes n output words (at most four). At end of
// source the pending token is finished, an open comment or literal is
// abandoned, and the lexer returns to idle for the next source.
`default_nettype none

module c_token_splitter (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] in_byte
    input  wire logic       s_tlast,   // end_of_input
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // [7:0] out_byte
    output logic            m_tlast    // last_of_run
);

    logic              s_fire;
    logic              q_full, q_empty, q_pop;
    ctok_pkg::bundle_t front_bundle;
    ctok_pkg::bundle_t q_data;

    // accept while the queue can take a bundle
    assign s_tready = !q_full;
    assign s_fire   = s_tvalid && s_tready;

    ctok_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_fire (s_fire),
        .in_byte (s_tdata),
        .in_last (s_tlast),
        .bundle  (front_bundle)
    );

    // bytes that produce nothing never enter the queue
    ctok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_fire && (front_bundle.cnt != '0)),
        .push_data (front_bundle),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    ctok_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_empty  (q_empty),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/c_token_splitter_tb.sv -----
// self-checking testbench for the streaming c tokenizer, with its own lexer predictor
`timescale 1ns / 1ps

module c_token_splitter_tb;

    // lexer modes of the predictor
    typedef enum logic [3:0] {
        LX_IDLE, LX_NUM, LX_WORD, LX_OP, LX_SLASH, LX_BLOCK, LX_LINE, LX_CHAR, LX_STR
    } lex_mode_t;

    // kinds of source fragments for the random part
    typedef enum int {
        CK_WORD, CK_NUM, CK_OP, CK_PUNCT, CK_BLANK, CK_STR, CK_CHAR, CK_BLOCK,
        CK_LINE, CK_SLASH, CK_NOISE
    } chunk_t;

    // one source byte; typed rows carry their token bytes, byte 0 in the low bits
    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic        typed;
        logic [2:0]  n;
        logic [31:0] bytes;
    } plan_row_t;

    // one token byte still owed by the block
    typedef struct packed {
        logic [7:0] ch;
        logic       tail;
    } tok_byte_t;

    localparam logic [7:0] NL    = ctok_pkg::CH_NL;
    localparam logic [7:0] TAB   = 8'd9;
    localparam logic [7:0] SPACE = 8'd32;
    localparam logic [7:0] DQ    = 8'd34;
    localparam logic [7:0] SQ    = 8'd39;
    localparam logic [7:0] STAR  = 8'd42;
    localparam logic [7:0] SLASH = 8'd47;
    localparam logic [7:0] BSL   = 8'd92;
    localparam logic [7:0] UNDER = 8'd95;

    localparam string OP_HEADS   = "+-*=&|^%!><";
    localparam string PAIR_TAILS = "+-=><&|";
    localparam string PUNCTS     = "~#[]{};:()?.";

    localparam int RANDOM_WORDS = 340;
    localparam int QUIET_LIMIT  = 5000;
    localparam int SETTLE       = 20;

    // directed part: extremes after reset and the lone slash at end of source
    // are typed in, the rest goes through the predictor
    localparam plan_row_t DIRECTED_PLAN [0:24] = '{
        '{8'h00, 1'b0, 1'b1, 3'd0, 32'h0},         // nul after reset: dropped
        '{8'hFF, 1'b0, 1'b1, 3'd0, 32'h0},         // high byte: dropped
        '{"a",   1'b0, 1'b0, 3'd0, 32'h0},         // identifier starts
        '{"1",   1'b0, 1'b0, 3'd0, 32'h0},         // digit after letters starts a number
        '{"+",   1'b0, 1'b0, 3'd0, 32'h0},         // number ends, operator starts
        '{"=",   1'b0, 1'b0, 3'd0, 32'h0},         // pairs into +=
        '{SLASH, 1'b0, 1'b0, 3'd0, 32'h0},
        '{STAR,  1'b0, 1'b0, 3'd0, 32'h0},         // block comment opens
        '{SLASH, 1'b0, 1'b0, 3'd0, 32'h0},         // opening star closes it
        '{DQ,    1'b0, 1'b0, 3'd0, 32'h0},         // string literal
        '{BSL,   1'b0, 1'b0, 3'd0, 32'h0},
        '{DQ,    1'b0, 1'b0, 3'd0, 32'h0},         // escaped quote stays inside
        '{DQ,    1'b0, 1'b0, 3'd0, 32'h0},         // closing quote
        '{SQ,    1'b0, 1'b0, 3'd0, 32'h0},         // char literal
        '{"x",   1'b0, 1'b0, 3'd0, 32'h0},
        '{SQ,    1'b0, 1'b0, 3'd0, 32'h0},
        '{UNDER, 1'b0, 1'b0, 3'd0, 32'h0},         // leading underscore: dropped
        '{SLASH, 1'b0, 1'b0, 3'd0, 32'h0},
        '{SLASH, 1'b0, 1'b0, 3'd0, 32'h0},         // line comment
        '{"q",   1'b0, 1'b0, 3'd0, 32'h0},
        '{NL,    1'b0, 1'b0, 3'd0, 32'h0},         // newline ends the comment
        '{"(",   1'b0, 1'b0, 3'd0, 32'h0},         // punctuation
        '{SLASH, 1'b1, 1'b1, 3'd2, 32'h0000_0A2F}, // lone slash at end: "/" and newline
        '{DQ,    1'b0, 1'b0, 3'd0, 32'h0},
        '{"z",   1'b1, 1'b0, 3'd0, 32'h0}          // open string abandoned at end
    };

    logic       aclk     = 1'b0;
    logic       aresetn;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;   // [7:0] in_byte
    logic       s_tlast;   // end_of_input
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;   // [7:0] out_byte
    logic       m_tlast;   // last_of_run

    // predictor state
    lex_mode_t  lex_st    = LX_IDLE;
    logic [7:0] held_op   = 8'd0;
    logic       prev_mark = 1'b0;
    logic [7:0] out_buf [4];
    int         out_cnt;

    tok_byte_t  tok_due [$];   // token bytes predicted, not yet seen
    plan_row_t  typed_q [$];   // one entry per word offered to the block
    logic [7:0] src_text [$];  // random source under construction
    int         err_cnt     = 0;
    int         quiet_ticks = 0;
    bit         calm        = 1'b0;   // no idling on either side while set

    c_token_splitter u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ---------------------------------------------------------------- predictor

    function automatic bit digit_ch(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit letter_ch(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic bit op_head(input logic [7:0] c);
        case (c)
            "+", "-", "*", "=", "&", "|", "^", "%", "!", ">", "<": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic bit punct_ch(input logic [7:0] c);
        case (c)
            "~", "#", "[", "]", "{", "}", ";", ":", "(", ")", "?", ".": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // does c complete a two-character operator started by first
    function automatic bit pairs_with(input logic [7:0] first, input logic [7:0] c);
        case (first)
            "+": return c == "+" || c == "=";
            "-": return c == "-" || c == ">" || c == "=";
            "&": return c == "&" || c == "=";
            "|": return c == "|" || c == "=";
            ">": return c == ">" || c == "=";
            "<": return c == "<" || c == "=";
            "*", "=", "^", "%", "!": return c == "=";
            default: return 1'b0;
        endcase
    endfunction

    // a source byte never yields more than four token bytes, extras are lost
    function automatic void put_byte(input logic [7:0] c);
        if (out_cnt < ctok_pkg::MAX_OUT) begin
            out_buf[out_cnt] = c;
            out_cnt++;
        end
    endfunction

    // handle c as the first byte of a new token
    function automatic void open_token(input logic [7:0] c);
        lex_st = LX_IDLE;
        if (op_head(c)) begin
            put_byte(c);
            held_op = c;
            lex_st  = LX_OP;
        end else if (c == SLASH) begin
            lex_st = LX_SLASH;
        end else if (punct_ch(c)) begin
            put_byte(c);
            put_byte(NL);
        end else if (c == SQ) begin
            put_byte(c);
            lex_st = LX_CHAR;
        end else if (c == DQ) begin
            put_byte(c);
            prev_mark = 1'b0;
            lex_st    = LX_STR;
        end else if (digit_ch(c)) begin
            put_byte(c);
            lex_st = LX_NUM;
        end else if (letter_ch(c)) begin
            put_byte(c);
            lex_st = LX_WORD;
        end
    endfunction

    // advance the lexer by one source byte, token bytes land in out_buf
    function automatic void lex_step(input logic [7:0] c, input logic eoi);
        out_cnt = 0;
        case (lex_st)
            LX_NUM: begin
                if (digit_ch(c)) begin
                    put_byte(c);
                end else begin
                    put_byte(NL);
                    open_token(c);
                end
            end
            LX_WORD: begin
                if (letter_ch(c) || c == UNDER) begin
                    put_byte(c);
                end else begin
                    put_byte(NL);
                    open_token(c);
                end
            end
            LX_OP: begin
                if (pairs_with(held_op, c)) begin
                    put_byte(c);
                    put_byte(NL);
                    lex_st = LX_IDLE;
                end else begin
                    put_byte(NL);
                    open_token(c);
                end
            end
            LX_SLASH: begin
                if (c == STAR) begin
                    lex_st    = LX_BLOCK;
                    prev_mark = 1'b1;   // the opening star may close the comment
                end else if (c == SLASH) begin
                    lex_st = LX_LINE;
                end else if (c == "=") begin
                    put_byte(SLASH);
                    put_byte("=");
                    put_byte(NL);
                    lex_st = LX_IDLE;
                end else begin
                    put_byte(SLASH);
                    put_byte(NL);
                    open_token(c);
                end
            end
            LX_BLOCK: begin
                if (prev_mark && c == SLASH) begin
                    lex_st    = LX_IDLE;
                    prev_mark = 1'b0;
                end else begin
                    prev_mark = (c == STAR);
                end
            end
            LX_LINE: begin
                if (c == NL) lex_st = LX_IDLE;
            end
            LX_CHAR: begin
                put_byte(c);
                if (c == SQ) begin
                    put_byte(NL);
                    lex_st = LX_IDLE;
                end
            end
            LX_STR: begin
                put_byte(c);
                if (c == DQ && !prev_mark) begin
                    put_byte(NL);
                    lex_st    = LX_IDLE;
                    prev_mark = 1'b0;
                end else begin
                    prev_mark = (c == BSL);
                end
            end
            default: begin
                if (c != SPACE && c != TAB && c != NL) open_token(c);
            end
        endcase

        // end of source: finish a pending token, drop open comments and literals
        if (eoi) begin
            if (lex_st == LX_NUM || lex_st == LX_WORD || lex_st == LX_OP) begin
                put_byte(NL);
            end else if (lex_st == LX_SLASH) begin
                put_byte(SLASH);
                put_byte(NL);
            end
            lex_st    = LX_IDLE;
            held_op   = 8'd0;
            prev_mark = 1'b0;
        end
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_miss(input string what);
        err_cnt++;
        $display("%0t mismatch: %s", $realtime, what);
    endtask

    // input and output words are both taken at the same edge, inputs first,
    // so the outcome never depends on process order within a time step
    always @(posedge aclk) begin : scoreboard
        plan_row_t row;
        tok_byte_t want;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                row = typed_q.pop_front();
                lex_step(s_tdata, s_tlast);
                if (row.typed) begin
                    for (int k = 0; k < row.n; k++)
                        tok_due.push_back({row.bytes[8*k +: 8], k == row.n - 1});
                end else begin
                    for (int k = 0; k < out_cnt; k++)
                        tok_due.push_back({out_buf[k], k == out_cnt - 1});
                end
            end

            if (m_tvalid && m_tready) begin
                if (tok_due.size() == 0) begin
                    report_miss($sformatf("unexpected word %h last %b", m_tdata, m_tlast));
                end else begin
                    want = tok_due.pop_front();
                    if (m_tdata !== want.ch)
                        report_miss($sformatf("out_byte %h, want %h", m_tdata, want.ch));
                    if (m_tlast !== want.tail)
                        report_miss($sformatf("last_of_run %b, want %b on byte %h",
                                              m_tlast, want.tail, want.ch));
                end
            end

            // watchdog on cycles with no word moving either way
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_ticks = 0;
            end else begin
                quiet_ticks++;
                if (quiet_ticks >= QUIET_LIMIT) begin
                    $display("c_token_splitter_tb: errors");
                    $finish;
                end
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    // receiver stalls about one cycle in five unless calm
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 20);
    end

    // offer one word and hold it until taken, then maybe idle a little
    task automatic send_word(input plan_row_t row);
        typed_q.push_back(row);
        s_tvalid <= 1'b1;
        s_tdata  <= row.ch;
        s_tlast  <= row.eoi;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (!calm && $urandom_range(0, 99) < 12) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    // stop sending until every predicted token byte has come out
    task automatic drain_wait();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tok_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1)) return 8'(65 + $urandom_range(0, 25));
        return 8'(97 + $urandom_range(0, 25));
    endfunction

    // append one well-formed fragment of c, or one noise byte
    task automatic add_chunk(input chunk_t kind);
        int idx;
        case (kind)
            CK_WORD: begin
                src_text.push_back(rand_letter());
                repeat ($urandom_range(0, 5))
                    src_text.push_back(($urandom_range(0, 4) == 0) ? UNDER : rand_letter());
            end
            CK_NUM: begin
                repeat ($urandom_range(1, 4)) src_text.push_back(8'(48 + $urandom_range(0, 9)));
            end
            CK_OP: begin
                src_text.push_back(OP_HEADS[$urandom_range(0, 10)]);
                if ($urandom_range(0, 2) != 0) src_text.push_back(PAIR_TAILS[$urandom_range(0, 6)]);
            end
            CK_PUNCT: begin
                src_text.push_back(PUNCTS[$urandom_range(0, 11)]);
            end
            CK_BLANK: begin
                repeat ($urandom_range(1, 3)) begin
                    idx = $urandom_range(0, 2);
                    src_text.push_back(idx == 0 ? SPACE : (idx == 1 ? TAB : NL));
                end
            end
            CK_STR: begin
                // backslashes and quotes inside exercise the escape rule
                src_text.push_back(DQ);
                repeat ($urandom_range(0, 5)) begin
                    idx = $urandom_range(0, 5);
                    case (idx)
                        0:       src_text.push_back(BSL);
                        1:       src_text.push_back(DQ);
                        2:       src_text.push_back(SPACE);
                        default: src_text.push_back(rand_letter());
                    endcase
                end
                src_text.push_back(DQ);
            end
            CK_CHAR: begin
                src_text.push_back(SQ);
                repeat ($urandom_range(0, 2)) src_text.push_back(8'($urandom_range(32, 126)));
                src_text.push_back(SQ);
            end
            CK_BLOCK: begin
                src_text.push_back(SLASH);
                src_text.push_back(STAR);
                repeat ($urandom_range(0, 5)) begin
                    idx = $urandom_range(0, 3);
                    src_text.push_back(idx == 0 ? STAR : (idx == 1 ? SLASH :
                                       (idx == 2 ? SPACE : rand_letter())));
                end
                src_text.push_back(STAR);
                src_text.push_back(SLASH);
            end
            CK_LINE: begin
                src_text.push_back(SLASH);
                src_text.push_back(SLASH);
                repeat ($urandom_range(0, 4)) src_text.push_back(rand_letter());
                src_text.push_back(NL);
            end
            CK_SLASH: begin
                // slash-equals, or a lone slash ended by a letter or punctuation
                src_text.push_back(SLASH);
                idx = $urandom_range(0, 2);
                src_text.push_back(idx == 0 ? 8'("=") :
                                   (idx == 1 ? rand_letter() : PUNCTS[$urandom_range(0, 11)]));
            end
            default: begin
                src_text.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    initial begin : stimulus
        int  sent;
        int  len;
        bit  mid_drained;
        sent        = 0;
        mid_drained = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 8'd0;
        s_tlast  <= 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_PLAN[i]) send_word(DIRECTED_PLAN[i]);
        drain_wait();

        // random sources: strings of c fragments, cut at a random length so the
        // end of source also lands inside literals and comments
        while (sent < RANDOM_WORDS) begin
            len = $urandom_range(4, 40);
            src_text.delete();
            while (src_text.size() < len) add_chunk(chunk_t'($urandom_range(0, CK_NOISE)));
            while (src_text.size() > len) void'(src_text.pop_back());
            for (int i = 0; i < len; i++) begin
                calm = (sent >= 120 && sent < 220);
                send_word(plan_row_t'{src_text[i], i == len - 1, 1'b0, 3'd0, 32'h0});
                sent++;
            end
            if (!mid_drained && sent >= 280) begin
                drain_wait();
                mid_drained = 1'b1;
            end
        end
        calm = 1'b0;

        drain_wait();
        repeat (SETTLE) @(posedge aclk);
        if (tok_due.size() != 0)
            report_miss($sformatf("%0d token bytes never came out", tok_due.size()));
        if (err_cnt == 0) begin
            $display("c_token_splitter_tb: clean");
        end else begin
            $display("c_token_splitter_tb: errors");
        end
        $finish;
    end

endmodule
